// ===== hdl/fcpr_pkg.sv =====
package fcpr_pkg;

	localparam int unsigned CtrlLen = 7;
	localparam logic [16:0] AgeMax = 17'h1FFFF;

	typedef enum logic [2:0] {
		PH_HDR1 = 3'd0,
		PH_HDR2 = 3'd1,
		PH_TYPE = 3'd2,
		PH_LEN  = 3'd3,
		PH_DATA = 3'd4,
		PH_SUM  = 3'd5
	} fcpr_phase_t;

	typedef enum logic [1:0] {
		REG_HEADER_FIRST  = 2'd0,
		REG_HEADER_SECOND = 2'd1,
		REG_CONTROL_TYPE  = 2'd2,
		REG_TIMEOUT_TICKS = 2'd3
	} fcpr_reg_t;

	typedef logic [CtrlLen-1:0][7:0] fcpr_fields_t;

	// One processed item as seen by the link/output stage
	typedef struct packed {
		logic         fire;
		logic         tick;
		logic         accept;
		fcpr_fields_t data;
	} fcpr_evt_t;

endpackage

// ===== hdl/fcpr_parser.sv =====
module fcpr_parser
	import fcpr_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	input  logic [7:0] header_first,
	input  logic [7:0] header_second,
	input  logic [7:0] control_type,
	output fcpr_evt_t  evt
);

	localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD);

	fcpr_phase_t  phase_q, phase_d;
	logic [7:0]   type_q, type_d;
	logic [7:0]   len_q, len_d;
	logic [7:0]   idx_q, idx_d;
	logic [7:0]   xor_q, xor_d;
	logic         accept;
	logic         byte_step;
	fcpr_fields_t pl_q;

	assign byte_step = step && !kind;

	always_comb begin
		phase_d = phase_q;
		type_d  = type_q;
		len_d   = len_q;
		idx_d   = idx_q;
		xor_d   = xor_q;
		accept  = 1'b0;
		case (phase_q)
			PH_HDR2: begin
				// a mismatching byte is not retried as a first header
				phase_d = (rx_byte == header_second) ? PH_TYPE : PH_HDR1;
			end
			PH_TYPE: begin
				type_d  = rx_byte;
				xor_d   = rx_byte;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d = rx_byte;
				xor_d = xor_q ^ rx_byte;
				if ({1'b0, rx_byte} > MaxLen) begin
					phase_d = PH_HDR1;
				end else begin
					idx_d   = 8'd0;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				idx_d = idx_q + 8'd1;
				xor_d = xor_q ^ rx_byte;
				// zero length still takes one byte
				if (({1'b0, idx_q} + 9'd1) >= {1'b0, len_q}) begin
					phase_d = PH_SUM;
				end
			end
			PH_SUM: begin
				accept  = (xor_q == rx_byte) && (type_q == control_type) &&
				          (len_q == 8'(CtrlLen));
				phase_d = PH_HDR1;
			end
			default: begin
				xor_d   = 8'd0;
				phase_d = (rx_byte == header_first) ? PH_HDR2 : PH_HDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR1;
			type_q  <= 8'd0;
			len_q   <= 8'd0;
			idx_q   <= 8'd0;
			xor_q   <= 8'd0;
		end else if (byte_step) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			xor_q   <= xor_d;
		end
	end

	// only the first seven payload bytes are ever read back
	always_ff @(posedge clk) begin
		for (int i = 0; i < CtrlLen; i++) begin
			if (byte_step && phase_q == PH_DATA && idx_q == 8'(i)) begin
				pl_q[i] <= rx_byte;
			end
		end
	end

	assign evt.fire   = step;
	assign evt.tick   = kind;
	assign evt.accept = byte_step && accept;
	assign evt.data   = pl_q;

endmodule

// ===== hdl/fcpr_link.sv =====
module fcpr_link
	import fcpr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  fcpr_evt_t    evt,
	input  logic [15:0]  timeout_ticks,
	output fcpr_fields_t fields,
	output logic         link_ok,
	output logic         frame_accepted
);

	logic [16:0]  age_q, age_d;
	fcpr_fields_t fields_q, fields_d;
	logic         link_q, link_d;
	logic         acc_q;

	always_comb begin
		age_d = age_q;
		if (evt.accept) begin
			age_d = 17'd0;
		end else if (evt.tick && age_q != AgeMax) begin
			age_d = age_q + 17'd1;
		end
		link_d   = age_d <= {1'b0, timeout_ticks};
		fields_d = evt.accept ? evt.data : fields_q;
		if (!link_d) begin
			fields_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q    <= 17'd0;
			fields_q <= '0;
			link_q   <= 1'b1;
			acc_q    <= 1'b0;
		end else if (evt.fire) begin
			age_q    <= age_d;
			fields_q <= fields_d;
			link_q   <= link_d;
			acc_q    <= evt.accept;
		end
	end

	assign fields         = fields_q;
	assign link_ok        = link_q;
	assign frame_accepted = acc_q;

endmodule

// ===== hdl/framed_control_packet_receiver_core.sv =====
// Framed control packet receiver. Each transaction on the input carries either a
// received byte (kind 0) or a millisecond tick (kind 1), and produces exactly one
// output transaction with the current control fields, link status and a flag that
// marks the byte closing an accepted control frame. One item per clock is
// sustained while out_stall is low; each item passes the input register, then
// the parser/age update that loads the result register. Registers are written
// through the cfg port and should only change while no transaction is in flight.
module framed_control_packet_receiver_core
	import fcpr_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        buttons,
	output logic [7:0]        misc,
	output logic [7:0]        dpad,
	output logic signed [7:0] axis_x,
	output logic signed [7:0] axis_y,
	output logic signed [7:0] axis_rx,
	output logic signed [7:0] axis_ry,
	output logic              link_ok,
	output logic              frame_accepted,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	logic         valid_s1;
	logic         kind_s1;
	logic [7:0]   byte_s1;
	logic         out_valid_q;
	logic         advance;
	logic         fire;
	logic         in_take;
	logic [7:0]   header_first_q;
	logic [7:0]   header_second_q;
	logic [7:0]   control_type_q;
	logic [15:0]  timeout_ticks_q;
	fcpr_evt_t    evt;
	fcpr_fields_t fields;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1 <= kind;
			byte_s1 <= rx_byte;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= 8'd170;
			header_second_q <= 8'd85;
			control_type_q  <= 8'd1;
			timeout_ticks_q <= 16'd500;
		end else if (cfg_valid && cfg_ready) begin
			case (fcpr_reg_t'(cfg_index))
				REG_HEADER_FIRST:  header_first_q  <= cfg_data[7:0];
				REG_HEADER_SECOND: header_second_q <= cfg_data[7:0];
				REG_CONTROL_TYPE:  control_type_q  <= cfg_data[7:0];
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fcpr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (fire),
		.kind         (kind_s1),
		.rx_byte      (byte_s1),
		.header_first (header_first_q),
		.header_second(header_second_q),
		.control_type (control_type_q),
		.evt          (evt)
	);

	fcpr_link u_link (
		.clk           (clk),
		.arst_n        (arst_n),
		.evt           (evt),
		.timeout_ticks (timeout_ticks_q),
		.fields        (fields),
		.link_ok       (link_ok),
		.frame_accepted(frame_accepted)
	);

	assign out_valid = out_valid_q;
	assign buttons   = fields[0];
	assign misc      = fields[1];
	assign dpad      = fields[2];
	assign axis_x    = fields[3];
	assign axis_y    = fields[4];
	assign axis_rx   = fields[5];
	assign axis_ry   = fields[6];

endmodule

// ===== bench/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fcpr_pkg::*;

	localparam int unsigned MaxPayload = 16;

	typedef struct {
		fcpr_fields_t fields;
		logic         link;
		logic         acc;
	} frame_report_t;

	// Tracks parser and link state, queues the expected report for every transaction.
	class control_frame_tracker;
		logic [7:0]    hdr_first;
		logic [7:0]    hdr_second;
		logic [7:0]    ctrl_type;
		logic [15:0]   timeout;
		fcpr_phase_t   phase;
		logic [7:0]    frm_type;
		logic [7:0]    frm_len;
		logic [7:0]    pay_idx;
		logic [7:0]    sum_acc;
		logic [7:0]    pay_buf [MaxPayload];
		fcpr_fields_t  fields;
		logic [16:0]   age;
		frame_report_t expected_reports[$];
		int            errors;

		function new();
			hdr_first = 8'd170;
			hdr_second = 8'd85;
			ctrl_type = 8'd1;
			timeout = 16'd500;
			phase = PH_HDR1;
			frm_type = '0;
			frm_len = '0;
			pay_idx = '0;
			sum_acc = '0;
			foreach (pay_buf[i]) pay_buf[i] = '0;
			fields = '0;
			age = '0;
			errors = 0;
		endfunction

		function void set_reg(fcpr_reg_t idx, logic [15:0] value);
			case (idx)
				REG_HEADER_FIRST: hdr_first = value[7:0];
				REG_HEADER_SECOND: hdr_second = value[7:0];
				REG_CONTROL_TYPE: ctrl_type = value[7:0];
				REG_TIMEOUT_TICKS: timeout = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void take_item(logic is_tick, logic [7:0] b);
			frame_report_t r;
			logic hit;
			hit = 1'b0;
			if (is_tick) begin
				if (age != AgeMax) age = age + 17'd1;
			end else begin
				case (phase)
					PH_HDR2: phase = (b == hdr_second) ? PH_TYPE : PH_HDR1;
					PH_TYPE: begin
						frm_type = b;
						sum_acc = b;
						phase = PH_LEN;
					end
					PH_LEN: begin
						frm_len = b;
						sum_acc = sum_acc ^ b;
						if (b > MaxPayload) begin
							phase = PH_HDR1;
						end else begin
							pay_idx = '0;
							phase = PH_DATA;
						end
					end
					PH_DATA: begin
						if (pay_idx < MaxPayload)
							pay_buf[pay_idx[$clog2(MaxPayload)-1:0]] = b;
						pay_idx = pay_idx + 8'd1;
						sum_acc = sum_acc ^ b;
						// zero length still eats one byte here
						if (pay_idx >= frm_len) phase = PH_SUM;
					end
					PH_SUM: begin
						if (sum_acc == b && frm_type == ctrl_type && frm_len == CtrlLen) begin
							for (int i = 0; i < CtrlLen; i++) fields[i] = pay_buf[i];
							age = '0;
							hit = 1'b1;
						end
						phase = PH_HDR1;
					end
					default: begin
						sum_acc = '0;
						phase = (b == hdr_first) ? PH_HDR2 : PH_HDR1;
					end
				endcase
			end
			// lost link wipes the stored fields until an accepted frame loads them again
			if (age > {1'b0, timeout}) fields = '0;
			r.fields = fields;
			r.link = (age <= {1'b0, timeout});
			r.acc = hit;
			expected_reports.push_back(r);
		endfunction

		function void flag(string what, int unsigned exp, int unsigned act);
			errors++;
			$display("%0t ns: %s expected 0x%0h got 0x%0h", $time, what, exp, act);
		endfunction

		function void check_result(fcpr_fields_t got, logic got_link, logic got_acc);
			frame_report_t e;
			string names [CtrlLen] = '{"buttons", "misc", "dpad", "axis_x", "axis_y",
				"axis_rx", "axis_ry"};
			if (expected_reports.size() == 0) begin
				errors++;
				$display("%0t ns: result with nothing expected, buttons 0x%0h link_ok %0b",
					$time, got[0], got_link);
				return;
			end
			e = expected_reports.pop_front();
			for (int i = 0; i < CtrlLen; i++)
				if (got[i] !== e.fields[i]) flag(names[i], e.fields[i], got[i]);
			if (got_link !== e.link) flag("link_ok", e.link, got_link);
			if (got_acc !== e.acc) flag("frame_accepted", e.acc, got_acc);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              kind;
	logic [7:0]        rx_byte;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        buttons;
	logic [7:0]        misc;
	logic [7:0]        dpad;
	logic signed [7:0] axis_x;
	logic signed [7:0] axis_y;
	logic signed [7:0] axis_rx;
	logic signed [7:0] axis_ry;
	logic              link_ok;
	logic              frame_accepted;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [15:0]       cfg_data;

	control_frame_tracker sb = new();
	bit idle_on = 1'b1;
	int hold_request = 0;
	int n_items = 0;

	framed_control_packet_receiver_core #(
		.MAX_PAYLOAD(MaxPayload)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.buttons(buttons),
		.misc(misc),
		.dpad(dpad),
		.axis_x(axis_x),
		.axis_y(axis_y),
		.axis_rx(axis_rx),
		.axis_ry(axis_ry),
		.link_ok(link_ok),
		.frame_accepted(frame_accepted),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({axis_ry, axis_rx, axis_y, axis_x, dpad, misc, buttons},
				link_ok, frame_accepted);
	end

	// result side: random stall per transaction, plus one long hold-off on request
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_request > 0) begin
				out_stall <= 1'b1;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end else begin
				n = idle_on ? $urandom_range(0, 5) : 0;
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		#4_000_000;
		$display("[framed_control_packet_receiver_core] ERROR");
		$finish;
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic fcpr_fields_t pick_fields();
		fcpr_fields_t f;
		for (int i = 0; i < CtrlLen; i++) f[i] = pick_byte();
		return f;
	endfunction

	// entered and left at a falling edge; valid stays up when the next item follows at once
	task automatic push_item(logic is_tick, logic [7:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= is_tick;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.take_item(is_tick, b);
		n_items++;
		@(negedge clk);
	endtask

	task automatic send_frame(logic [7:0] typ, logic [7:0] len, fcpr_fields_t head,
			bit bad_sum);
		logic [7:0] x;
		logic [7:0] d;
		int n;
		push_item(1'b0, sb.hdr_first);
		push_item(1'b0, sb.hdr_second);
		push_item(1'b0, typ);
		push_item(1'b0, len);
		if (len > MaxPayload) return;
		x = typ ^ len;
		n = (len == 0) ? 1 : len;
		for (int i = 0; i < n; i++) begin
			d = (i < CtrlLen) ? head[i] : pick_byte();
			push_item(1'b0, d);
			x = x ^ d;
		end
		push_item(1'b0, bad_sum ? x ^ (8'd1 << $urandom_range(0, 7)) : x);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(fcpr_reg_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// upper byte of 8-bit registers is junk on purpose, block must drop it
	task automatic configure(logic [7:0] h1, logic [7:0] h2, logic [7:0] ct, logic [15:0] tmo);
		write_reg(REG_HEADER_FIRST, {8'($urandom), h1});
		write_reg(REG_HEADER_SECOND, {8'($urandom), h2});
		write_reg(REG_CONTROL_TYPE, {8'($urandom), ct});
		write_reg(REG_TIMEOUT_TICKS, tmo);
	endtask

	task automatic random_traffic(int count);
		int stop_at;
		int pick;
		int k;
		logic [7:0] typ;
		logic [7:0] len;
		stop_at = n_items + count;
		while (n_items < stop_at) begin
			if ($urandom_range(0, 49) == 0) idle_on = !idle_on;
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				typ = ($urandom_range(0, 4) != 0) ? sb.ctrl_type : 8'($urandom);
				k = $urandom_range(0, 19);
				if (k < 14) len = 8'(CtrlLen);
				else if (k < 19) len = 8'($urandom_range(0, MaxPayload));
				else len = 8'($urandom_range(MaxPayload + 1, 255));
				send_frame(typ, len, pick_fields(), $urandom_range(0, 7) == 0);
			end else if (pick < 80) begin
				// occasional long tick run to cross the timeout
				if ($urandom_range(0, 3) == 0)
					k = $urandom_range(1, (sb.timeout < 48) ? sb.timeout + 3 : 50);
				else
					k = $urandom_range(1, 3);
				repeat (k) push_item(1'b1, 8'($urandom));
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 3)) push_item(1'b0, pick_byte());
			end else if ($urandom_range(0, 1) == 0) begin
				push_item(1'b0, sb.hdr_first);
				push_item(1'b0, ($urandom_range(0, 1) == 0) ? sb.hdr_first : 8'($urandom));
			end else begin
				// truncated frame, the next bytes land in its payload
				push_item(1'b0, sb.hdr_first);
				push_item(1'b0, sb.hdr_second);
				push_item(1'b0, sb.ctrl_type);
				push_item(1'b0, 8'(CtrlLen));
				repeat ($urandom_range(0, 5)) push_item(1'b0, pick_byte());
			end
		end
	endtask

	initial begin
		logic [7:0] h;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = 1'b0;
		rx_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_HEADER_FIRST;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: axis extremes, zero length, oversize length, bad second header
		send_frame(sb.ctrl_type, 8'(CtrlLen),
			{8'h7F, 8'h80, 8'h7F, 8'h80, 8'hA5, 8'h00, 8'hFF}, 1'b0);
		send_frame(sb.ctrl_type, 8'd0, pick_fields(), 1'b0);
		send_frame(sb.ctrl_type, 8'(MaxPayload + 1), '0, 1'b0);
		push_item(1'b0, sb.hdr_first);
		push_item(1'b0, sb.hdr_first);
		push_item(1'b1, 8'hFF);

		random_traffic(250);
		settle();

		configure(8'h00, 8'hFF, 8'hFF, 16'd0);
		random_traffic(280);
		settle();

		configure(8'hFF, 8'h00, 8'h00, 16'hFFFF);
		random_traffic(280);
		settle();

		h = 8'($urandom);
		configure(h, h, 8'($urandom), 16'($urandom_range(1, 40)));
		random_traffic(280);
		settle();

		configure(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(0, 20)));
		hold_request = 200;
		random_traffic(280);
		settle();

		configure(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(5, 40)));
		random_traffic(280);
		settle();

		// run the age past the timeout, then recover with a good frame
		write_reg(REG_TIMEOUT_TICKS, 16'd20);
		send_frame(sb.ctrl_type, 8'(CtrlLen), pick_fields(), 1'b0);
		idle_on = 1'b0;
		repeat (30) push_item(1'b1, 8'($urandom));
		send_frame(sb.ctrl_type, 8'(CtrlLen), pick_fields(), 1'b0);
		idle_on = 1'b1;
		settle();
		repeat (4) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[framed_control_packet_receiver_core] OK");
		end else begin
			if (sb.pending() != 0)
				$display("%0t ns: %0d expected results never arrived", $time, sb.pending());
			$display("[framed_control_packet_receiver_core] ERROR");
		end
		$finish;
	end

endmodule
